/* hdl/agpc_pkg.sv */
`default_nettype none
package agpc_pkg;

   localparam int ADC_BITS       = 10;
   localparam int COEF_FRAC_BITS = 16;

   localparam int SAMPLE_W = 10;
   localparam int MV_W     = 13;
   localparam int PPB_W    = 28;
   localparam int GAIN_W   = 2;
   localparam int REQG_W   = 8;
   localparam int MAXP_W   = 16;
   localparam int PROD_W   = SAMPLE_W + MV_W;
   localparam int COEF_W   = 24;
   localparam int OFS_W    = 20;
   localparam int FIT_W    = MV_W + COEF_W;
   localparam int SUM_W    = FIT_W + 9;

   localparam logic [PROD_W-1:0] ADC_FULL = PROD_W'((1 << ADC_BITS) - 1);
   localparam logic [MV_W-1:0]   MV_MAX   = MV_W'(8191);

   // slope rounding from Q24 down to the coefficient format
   localparam int COEF_DOWN = 24 - COEF_FRAC_BITS;
   localparam logic [COEF_W:0] COEF_RND =
      (COEF_DOWN > 0) ? (COEF_W+1)'(1 << (COEF_DOWN - 1)) : '0;
   // product to Q16
   localparam int FIT_SR = (COEF_FRAC_BITS > 16) ? COEF_FRAC_BITS - 16 : 0;
   localparam int FIT_SL = (COEF_FRAC_BITS < 16) ? 16 - COEF_FRAC_BITS : 0;
   localparam logic [SUM_W-1:0] FIT_RND =
      (FIT_SR > 0) ? SUM_W'(1 << (FIT_SR - 1)) : '0;

   localparam logic signed [SUM_W:0] PPB_MAX = (SUM_W+1)'(134217727);
   localparam logic signed [SUM_W:0] PPB_MIN = -(SUM_W+1)'(16777216);

   localparam logic [GAIN_W-1:0] GAIN_X1   = 2'd0;
   localparam logic [GAIN_W-1:0] GAIN_X10  = 2'd1;
   localparam logic [GAIN_W-1:0] GAIN_X100 = 2'd2;

   localparam logic [1:0] RANGE_CDOM = 2'd0;
   localparam logic [1:0] RANGE_PHY  = 2'd1;
   localparam logic [1:0] RANGE_CHL  = 2'd2;
   localparam logic [1:0] RANGE_NONE = 2'd3;

   localparam logic [MAXP_W-1:0] MAXP_CDOM = 16'd1500;
   localparam logic [MAXP_W-1:0] MAXP_PHY  = 16'd750;
   localparam logic [MAXP_W-1:0] MAXP_CHL  = 16'd500;

   localparam logic [REQG_W-1:0] REQ_X1   = 8'd1;
   localparam logic [REQG_W-1:0] REQ_X10  = 8'd10;
   localparam logic [REQG_W-1:0] REQ_X100 = 8'd100;

   localparam logic OP_MEASURE = 1'b0;
   localparam logic OP_SET     = 1'b1;

   localparam logic [1:0] REG_FULL_SCALE = 2'd0;
   localparam logic [1:0] REG_MAX_PPB    = 2'd1;
   localparam logic [1:0] REG_LOW_THR    = 2'd2;
   localparam logic [1:0] REG_HIGH_MARG  = 2'd3;

   typedef struct packed {
      logic [MV_W-1:0]   full_scale_mv;
      logic [MAXP_W-1:0] max_ppb;
      logic [MV_W-1:0]   low_threshold_mv;
      logic [MV_W-1:0]   high_margin_mv;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic mul;
      logic div;
      logic adj;
      logic fit;
      logic load_out;
   } dp_cmd_type;

   // x / (2^ADC_BITS - 1) by folding the high part back in, then one correction
   function automatic logic [MV_W-1:0] div_full(input logic [PROD_W-1:0] x);
      logic [PROD_W-1:0] q0, r0, q1, r1, q;
      q0 = x >> ADC_BITS;
      r0 = (x & ADC_FULL) + q0;
      q1 = q0 + (r0 >> ADC_BITS);
      r1 = (r0 & ADC_FULL) + (r0 >> ADC_BITS);
      q  = (r1 >= ADC_FULL) ? q1 + PROD_W'(1) : q1;
      return (q > PROD_W'(MV_MAX)) ? MV_MAX : q[MV_W-1:0];
   endfunction

   function automatic logic [23:0] slope_q24(input logic [1:0] r, input logic [1:0] g);
      logic [23:0] s;
      case ({r, g})
         {RANGE_CDOM, GAIN_X1}:   s = 24'd5068397;
         {RANGE_CDOM, GAIN_X10}:  s = 24'd523449;
         {RANGE_CDOM, GAIN_X100}: s = 24'd55365;
         {RANGE_PHY,  GAIN_X1}:   s = 24'd2533360;
         {RANGE_PHY,  GAIN_X10}:  s = 24'd255014;
         {RANGE_PHY,  GAIN_X100}: s = 24'd26844;
         {RANGE_CHL,  GAIN_X1}:   s = 24'd1689466;
         {RANGE_CHL,  GAIN_X10}:  s = 24'd171128;
         {RANGE_CHL,  GAIN_X100}: s = 24'd16777;
         default:                 s = 24'd0;
      endcase
      return s;
   endfunction

   function automatic logic [OFS_W-1:0] offset_q16(input logic [1:0] r,
                                                   input logic [1:0] g);
      logic [OFS_W-1:0] o;
      case ({r, g})
         {RANGE_CDOM, GAIN_X1}:   o = 20'd686378;
         {RANGE_CDOM, GAIN_X10}:  o = 20'd402771;
         {RANGE_CDOM, GAIN_X100}: o = 20'd101948;
         {RANGE_PHY,  GAIN_X1}:   o = 20'd339889;
         {RANGE_PHY,  GAIN_X10}:  o = 20'd68197;
         {RANGE_PHY,  GAIN_X100}: o = 20'd47331;
         {RANGE_CHL,  GAIN_X1}:   o = 20'd230995;
         {RANGE_CHL,  GAIN_X10}:  o = 20'd49899;
         {RANGE_CHL,  GAIN_X100}: o = 20'd13651;
         default:                 o = 20'd0;
      endcase
      return o;
   endfunction

   function automatic logic [COEF_W-1:0] coef(input logic [1:0] r, input logic [1:0] g);
      logic [COEF_W:0] t;
      t = {1'b0, slope_q24(r, g)} + COEF_RND;
      t = t >> COEF_DOWN;
      return t[COEF_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* hdl/agpc_csr.sv */
`default_nettype none
module agpc_csr (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          psel,
   input  wire logic          penable,
   input  wire logic          pwrite,
   input  wire logic [3:0]    paddr,
   input  wire logic [31:0]   pwdata,
   output logic [31:0]        prdata,
   output agpc_pkg::cfg_type  cfg
);
   import agpc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] idx;
   logic       wr;

   assign idx = paddr[3:2];
   assign wr  = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_FULL_SCALE: cfg_in.full_scale_mv    = pwdata[MV_W-1:0];
            REG_MAX_PPB:    cfg_in.max_ppb          = pwdata[MAXP_W-1:0];
            REG_LOW_THR:    cfg_in.low_threshold_mv = pwdata[MV_W-1:0];
            REG_HIGH_MARG:  cfg_in.high_margin_mv   = pwdata[MV_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_FULL_SCALE: prdata = 32'(cfg_ff.full_scale_mv);
         REG_MAX_PPB:    prdata = 32'(cfg_ff.max_ppb);
         REG_LOW_THR:    prdata = 32'(cfg_ff.low_threshold_mv);
         REG_HIGH_MARG:  prdata = 32'(cfg_ff.high_margin_mv);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_scale_mv    <= MV_W'(5000);
         cfg_ff.max_ppb          <= '0;
         cfg_ff.low_threshold_mv <= MV_W'(290);
         cfg_ff.high_margin_mv   <= MV_W'(500);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

/* hdl/agpc_ctrl.sv */
`default_nettype none
module agpc_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output agpc_pkg::dp_cmd_type  cmd
);
   import agpc_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_ADJ  = 3'd3;
   localparam logic [2:0] S_FIT  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       slot_free;

   assign slot_free  = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !rsp_tready;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div  = 1'b1;
            state_in = S_ADJ;
         end
         S_ADJ: begin
            cmd.adj  = 1'b1;
            state_in = S_FIT;
         end
         S_FIT: begin
            cmd.fit  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (slot_free) begin
               cmd.load_out = 1'b1;
               valid_in     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end
endmodule
`default_nettype wire

/* hdl/agpc_datapath.sv */
`default_nettype none
module agpc_datapath (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  agpc_pkg::dp_cmd_type          cmd,
   input  agpc_pkg::cfg_type             cfg,
   input  wire logic                     in_opcode,
   input  wire logic                     in_autogain,
   input  wire logic [agpc_pkg::SAMPLE_W-1:0] in_range_sample,
   input  wire logic [agpc_pkg::SAMPLE_W-1:0] in_measure_sample,
   input  wire logic [agpc_pkg::REQG_W-1:0]   in_requested_gain,
   output logic [agpc_pkg::GAIN_W-1:0]   out_gain_code,
   output logic                          out_x10_line,
   output logic                          out_x100_line,
   output logic [agpc_pkg::MV_W-1:0]     out_millivolts,
   output logic [agpc_pkg::PPB_W-1:0]    out_ppb_q16,
   output logic                          out_range_known
);
   import agpc_pkg::*;

   logic                opcode_ff, autog_ff;
   logic [SAMPLE_W-1:0] rs_ff, ms_ff;
   logic [REQG_W-1:0]   req_ff;
   logic [PROD_W-1:0]   prod_r_ff, prod_m_ff;
   logic [MV_W-1:0]     mv_r_ff, mv_m_ff;
   logic [GAIN_W-1:0]   gain_ff, gain_in;
   logic [FIT_W-1:0]    fit_ff;
   logic [OFS_W-1:0]    ofs_ff;
   logic [1:0]          range_idx;

   logic [GAIN_W-1:0] rgain_ff, gain_line;
   logic [MV_W-1:0]   rmv_ff;
   logic [PPB_W-1:0]  rppb_ff, ppb_sat;
   logic              rknown_ff;

   logic                 low, high;
   logic signed [MV_W:0] upper;
   logic [SUM_W-1:0]     scaled;
   logic signed [SUM_W:0] diff;

   always_comb begin
      if (cfg.max_ppb == MAXP_CDOM)     range_idx = RANGE_CDOM;
      else if (cfg.max_ppb == MAXP_PHY) range_idx = RANGE_PHY;
      else if (cfg.max_ppb == MAXP_CHL) range_idx = RANGE_CHL;
      else                              range_idx = RANGE_NONE;
   end

   // gain decision, set from the requested gain or, with autogain, checks cascade x1 -> x10 -> x100
   always_comb begin
      upper   = $signed({1'b0, cfg.full_scale_mv}) - $signed({1'b0, cfg.high_margin_mv});
      low     = mv_r_ff < cfg.low_threshold_mv;
      high    = $signed({1'b0, mv_r_ff}) > upper;
      gain_in = gain_ff;
      if (opcode_ff == OP_SET) begin
         if (req_ff == REQ_X1)        gain_in = GAIN_X1;
         else if (req_ff == REQ_X10)  gain_in = GAIN_X10;
         else if (req_ff == REQ_X100) gain_in = GAIN_X100;
      end else if (autog_ff) begin
         if (gain_in == GAIN_X1 && low) gain_in = GAIN_X10;
         if (gain_in == GAIN_X10) begin
            if (low)       gain_in = GAIN_X100;
            else if (high) gain_in = GAIN_X1;
         end
         if (gain_in == GAIN_X100 && high) gain_in = GAIN_X10;
      end
   end

   assign gain_line = (gain_ff > GAIN_X100) ? GAIN_X1 : gain_ff;

   always_comb begin
      scaled = ((SUM_W'(fit_ff) + FIT_RND) >> FIT_SR) << FIT_SL;
      diff   = $signed({1'b0, scaled}) - $signed((SUM_W+1)'(ofs_ff));
      if (diff > PPB_MAX)      ppb_sat = PPB_MAX[PPB_W-1:0];
      else if (diff < PPB_MIN) ppb_sat = PPB_MIN[PPB_W-1:0];
      else                     ppb_sat = diff[PPB_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         opcode_ff <= in_opcode;
         autog_ff  <= in_autogain;
         rs_ff     <= in_range_sample;
         ms_ff     <= in_measure_sample;
         req_ff    <= in_requested_gain;
      end
      if (cmd.mul) begin
         prod_r_ff <= PROD_W'(rs_ff) * PROD_W'(cfg.full_scale_mv);
         prod_m_ff <= PROD_W'(ms_ff) * PROD_W'(cfg.full_scale_mv);
      end
      if (cmd.div) begin
         mv_r_ff <= div_full(prod_r_ff);
         mv_m_ff <= div_full(prod_m_ff);
      end
      if (cmd.fit) begin
         fit_ff <= FIT_W'(mv_m_ff) * FIT_W'(coef(range_idx, gain_line));
         ofs_ff <= offset_q16(range_idx, gain_line);
      end
      if (cmd.load_out) begin
         rgain_ff  <= gain_ff;
         rknown_ff <= (range_idx != RANGE_NONE);
         if (opcode_ff == OP_SET) begin
            rmv_ff  <= '0;
            rppb_ff <= '0;
         end else begin
            rmv_ff  <= mv_m_ff;
            rppb_ff <= (range_idx == RANGE_NONE) ? '0 : ppb_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_X10;
      end else if (cmd.adj) begin
         gain_ff <= gain_in;
      end
   end

   assign out_gain_code   = rgain_ff;
   assign out_x10_line    = (rgain_ff != GAIN_X10);
   assign out_x100_line   = (rgain_ff != GAIN_X100);
   assign out_millivolts  = rmv_ff;
   assign out_ppb_q16     = rppb_ff;
   assign out_range_known = rknown_ff;
endmodule
`default_nettype wire

/* hdl/autorange_gain_ppb_converter_top.sv */
`default_nettype none
// Auto-ranging gain front end for a fluorometer channel. Each request beat either sets the
// gain (tuser = 1, requested gain 1, 10 or 100; other values leave it) or measures
// (tuser = 0), optionally stepping the gain from the range sample first, and returns one
// response beat with the gain, the select-line levels, the measure sample in millivolts and
// the concentration in signed Q16 ppb from the fit picked by max_ppb. Gain resets to x10;
// registers reset to full scale 5000 mV, max_ppb 0, low threshold 290 mV, margin 500 mV.
// Timing: one item at a time. Once the request beat is taken, the item is multiplied, divided by
// full scale, the gain is stepped, the fit multiplied, then offset and clamp load the output
// register once it is free, and the controller returns to idle for the next request. A new
// request is taken while a finished response still waits in the output register.
// The user must write registers only while no item is in flight; the block does not enforce it.
module autorange_gain_ppb_converter_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // autogain[0], range_sample[10:1], measure_sample[20:11], requested_gain[28:21]
   input  wire logic [31:0] req_tdata,
   // opcode[0]
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // gain_code[1:0], x10_line[2], x100_line[3], millivolts[16:4], ppb_q16[44:17],
   // range_known[45]
   output logic [47:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import agpc_pkg::*;

   cfg_type    cfg;
   dp_cmd_type cmd;

   logic [GAIN_W-1:0] gain_code;
   logic              x10_line, x100_line, range_known;
   logic [MV_W-1:0]   millivolts;
   logic [PPB_W-1:0]  ppb_q16;

   assign csr_pready = 1'b1;

   agpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   agpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   agpc_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg),
      .in_opcode         (req_tuser),
      .in_autogain       (req_tdata[0]),
      .in_range_sample   (req_tdata[10:1]),
      .in_measure_sample (req_tdata[20:11]),
      .in_requested_gain (req_tdata[28:21]),
      .out_gain_code     (gain_code),
      .out_x10_line      (x10_line),
      .out_x100_line     (x100_line),
      .out_millivolts    (millivolts),
      .out_ppb_q16       (ppb_q16),
      .out_range_known   (range_known)
   );

   assign rsp_tdata = {2'b00, range_known, ppb_q16, millivolts, x100_line, x10_line,
                       gain_code};
endmodule
`default_nettype wire

/* tb/autorange_gain_ppb_converter_top_test.sv */
`default_nettype none
module autorange_gain_ppb_converter_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import agpc_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int SETTLE_CYCLES = 10;
   localparam int PHASE_ITEMS  = 200;

   typedef struct packed {
      logic [GAIN_W-1:0]       gain;
      logic                    x10;
      logic                    x100;
      logic [MV_W-1:0]         mv;
      logic signed [PPB_W-1:0] ppb;
      logic                    known;
   } reading_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state and register copy
   logic [MV_W-1:0]   cfg_full_scale = 13'd5000;
   logic [MAXP_W-1:0] cfg_max_ppb    = 16'd0;
   logic [MV_W-1:0]   cfg_low_thr    = 13'd290;
   logic [MV_W-1:0]   cfg_high_marg  = 13'd500;
   logic [GAIN_W-1:0] gain_now       = GAIN_X10;

   reading_type pending_readings[$];
   int       fail_count = 0;
   int       idle_cycles = 0;
   int       rsp_hold = 0;
   bit       quiet = 1'b0;

   const longint slope_tab[3][3] = '{
      '{5068397, 523449, 55365},
      '{2533360, 255014, 26844},
      '{1689466, 171128, 16777}
   };
   const longint offset_tab[3][3] = '{
      '{686378, 402771, 101948},
      '{339889,  68197,  47331},
      '{230995,  49899,  13651}
   };

   autorange_gain_ppb_converter_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [MV_W-1:0] scale_mv(input logic [SAMPLE_W-1:0] s);
      longint m;
      m = longint'(s) * longint'(cfg_full_scale) / ((longint'(1) << ADC_BITS) - 1);
      if (m > 8191) m = 8191;
      return m[MV_W-1:0];
   endfunction

   function automatic int sensor_range();
      if (cfg_max_ppb == MAXP_CDOM) return 0;
      if (cfg_max_ppb == MAXP_PHY) return 1;
      if (cfg_max_ppb == MAXP_CHL) return 2;
      return -1;
   endfunction

   function automatic longint fit_ppb(input int r, input logic [GAIN_W-1:0] g,
                                      input logic [MV_W-1:0] mv);
      int     down;
      longint c;
      longint p;
      longint v;
      down = 24 - COEF_FRAC_BITS;
      c = slope_tab[r][g];
      if (down > 0) c = (c + (longint'(1) << (down - 1))) >> down;
      p = longint'(mv) * c;
      if (COEF_FRAC_BITS > 16)
         p = (p + (longint'(1) << (COEF_FRAC_BITS - 17))) >> (COEF_FRAC_BITS - 16);
      else if (COEF_FRAC_BITS < 16)
         p = p << (16 - COEF_FRAC_BITS);
      v = p - offset_tab[r][g];
      if (v > 134217727) v = 134217727;
      if (v < -16777216) v = -16777216;
      return v;
   endfunction

   // range decision; checks run x1, x10, x100 on the updated gain so steps cascade
   function automatic void step_gain(input logic [MV_W-1:0] mv);
      int upper;
      bit lo;
      bit hi;
      upper = int'(cfg_full_scale) - int'(cfg_high_marg);
      lo = mv < cfg_low_thr;
      hi = int'(mv) > upper;
      if (gain_now == GAIN_X1 && lo) gain_now = GAIN_X10;
      if (gain_now == GAIN_X10) begin
         if (lo) gain_now = GAIN_X100;
         else if (hi) gain_now = GAIN_X1;
      end
      if (gain_now == GAIN_X100 && hi) gain_now = GAIN_X10;
   endfunction

   function automatic reading_type predict_reading(input logic op, input logic ag,
                                                   input logic [SAMPLE_W-1:0] rs,
                                                   input logic [SAMPLE_W-1:0] ms,
                                                   input logic [REQG_W-1:0] rq);
      reading_type e;
      int       r;
      longint   v;
      r = sensor_range();
      e.mv = '0;
      e.ppb = '0;
      if (op == OP_SET) begin
         if (rq == REQ_X1) gain_now = GAIN_X1;
         else if (rq == REQ_X10) gain_now = GAIN_X10;
         else if (rq == REQ_X100) gain_now = GAIN_X100;
      end else begin
         if (ag) step_gain(scale_mv(rs));
         e.mv = scale_mv(ms);
         if (r >= 0) begin
            v = fit_ppb(r, gain_now, e.mv);
            e.ppb = v[PPB_W-1:0];
         end
      end
      e.gain = gain_now;
      e.x10 = (gain_now != GAIN_X10);
      e.x100 = (gain_now != GAIN_X100);
      e.known = (r >= 0);
      return e;
   endfunction

   function automatic int req_gap();
      if (quiet || $urandom_range(0, 7) != 0) return 0;
      return $urandom_range(1, 6);
   endfunction

   task automatic check_field(input string name, input int exp_v, input int got_v);
      if (exp_v != got_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
         fail_count++;
      end
   endtask

   // response checker
   always @(posedge clock) begin
      reading_type e;
      if (rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            $error("response beat with no reading outstanding");
            fail_count++;
         end else begin
            e = pending_readings.pop_front();
            check_field("gain_code", int'(e.gain), int'(rsp_tdata[1:0]));
            check_field("x10_line", int'(e.x10), int'(rsp_tdata[2]));
            check_field("x100_line", int'(e.x100), int'(rsp_tdata[3]));
            check_field("millivolts", int'(e.mv), int'(rsp_tdata[16:4]));
            check_field("ppb_q16", int'(e.ppb), int'($signed(rsp_tdata[44:17])));
            check_field("range_known", int'(e.known), int'(rsp_tdata[45]));
         end
      end
   end

   // response-side backpressure bursts
   always @(posedge clock) begin
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= $urandom_range(0, 5);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL autorange_gain_ppb_converter_top");
         $finish;
      end
   end

   task automatic send_sample(input logic op, input logic ag,
                              input logic [SAMPLE_W-1:0] rs,
                              input logic [SAMPLE_W-1:0] ms,
                              input logic [REQG_W-1:0] rq);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {3'b000, rq, ms, rs, ag};
      do @(posedge clock); while (!req_tready);
      pending_readings.push_back(predict_reading(op, ag, rs, ms, rq));
      gap = req_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_FULL_SCALE: cfg_full_scale = val[MV_W-1:0];
         REG_MAX_PPB:    cfg_max_ppb = val[MAXP_W-1:0];
         REG_LOW_THR:    cfg_low_thr = val[MV_W-1:0];
         REG_HIGH_MARG:  cfg_high_marg = val[MV_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input int fs, input logic [MAXP_W-1:0] mp, input int lo,
                               input int mg);
      settle_idle();
      write_reg(REG_FULL_SCALE, fs);
      write_reg(REG_MAX_PPB, 32'(mp));
      write_reg(REG_LOW_THR, lo);
      write_reg(REG_HIGH_MARG, mg);
   endtask

   task automatic send_random_sample();
      logic                op;
      logic                ag;
      logic [SAMPLE_W-1:0] rs;
      logic [SAMPLE_W-1:0] ms;
      logic [REQG_W-1:0]   rq;
      op = ($urandom_range(0, 3) == 0) ? OP_SET : OP_MEASURE;
      ag = ($urandom_range(0, 9) < 7);
      // bias toward low readings so step-up decisions come up often
      rs = SAMPLE_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 80)
                                                 : $urandom_range(0, 1023));
      ms = SAMPLE_W'($urandom_range(0, 1023));
      if ($urandom_range(0, 9) < 7) begin
         case ($urandom_range(0, 2))
            0:       rq = REQ_X1;
            1:       rq = REQ_X10;
            default: rq = REQ_X100;
         endcase
      end else begin
         rq = REQG_W'($urandom_range(0, 255));
      end
      send_sample(op, ag, rs, ms, rq);
   endtask

   // gain select, including ignored values, at reset config (no fit)
   task automatic test_gain_select();
      send_sample(OP_MEASURE, 1'b0, 10'd0, 10'd1023, 8'd0);
      send_sample(OP_SET, 1'b0, 10'd0, 10'd0, REQ_X1);
      send_sample(OP_MEASURE, 1'b0, 10'd1023, 10'd1023, 8'd255);
      send_sample(OP_SET, 1'b1, 10'd1023, 10'd1023, REQ_X100);
      send_sample(OP_SET, 1'b0, 10'd0, 10'd0, 8'd0);
      send_sample(OP_SET, 1'b0, 10'd0, 10'd0, 8'd255);
      send_sample(OP_SET, 1'b0, 10'd0, 10'd0, REQ_X10);
      send_sample(OP_SET, 1'b0, 10'd0, 10'd0, 8'd2);
      send_sample(OP_MEASURE, 1'b0, 10'd0, 10'd0, 8'd0);
   endtask

   task automatic test_autorange_steps();
      apply_config(8191, MAXP_CDOM, 290, 500);
      send_sample(OP_SET, 1'b0, 10'd0, 10'd0, REQ_X1);
      send_sample(OP_MEASURE, 1'b1, 10'd0, 10'd1023, 8'd0);     // x1 -> x100 cascade
      send_sample(OP_MEASURE, 1'b1, 10'd0, 10'd0, 8'd0);        // x100 holds when low
      send_sample(OP_MEASURE, 1'b1, 10'd1023, 10'd512, 8'd0);   // x100 -> x10
      send_sample(OP_MEASURE, 1'b1, 10'd1023, 10'd1023, 8'd0);  // x10 -> x1
      send_sample(OP_MEASURE, 1'b1, 10'd1023, 10'd1023, 8'd0);  // x1 holds when high
      send_sample(OP_MEASURE, 1'b1, 10'd500, 10'd1, 8'd0);
      send_sample(OP_MEASURE, 1'b0, 10'd0, 10'd300, 8'd0);
   endtask

   // margin above full scale makes the upper threshold negative
   task automatic test_negative_upper();
      apply_config(100, MAXP_CHL, 0, 8191);
      send_sample(OP_SET, 1'b0, 10'd0, 10'd0, REQ_X100);
      send_sample(OP_MEASURE, 1'b1, 10'd0, 10'd1023, 8'd0);
      send_sample(OP_MEASURE, 1'b1, 10'd0, 10'd1023, 8'd0);
      send_sample(OP_MEASURE, 1'b1, 10'd0, 10'd0, 8'd0);
   endtask

   task automatic test_random_phases();
      int                p;
      logic [MAXP_W-1:0] mp;
      for (p = 0; p < 8; p++) begin
         case (p)
            0: apply_config(5000, MAXP_CDOM, 290, 500);
            1: apply_config(5000, MAXP_PHY, 290, 500);
            2: apply_config(3300, MAXP_CHL, 200, 300);
            3: apply_config(8191, MAXP_CDOM, 0, 0);
            4: apply_config(0, MAXP_PHY, 8191, 8191);
            5: apply_config(8191, 16'hFFFF, 8191, 0);
            6: begin
               case ($urandom_range(0, 3))
                  0:       mp = MAXP_CDOM;
                  1:       mp = MAXP_PHY;
                  2:       mp = MAXP_CHL;
                  default: mp = MAXP_W'($urandom_range(0, 65535));
               endcase
               apply_config($urandom_range(0, 8191), mp, $urandom_range(0, 8191),
                            $urandom_range(0, 8191));
            end
            default: begin
               quiet = 1'b1;
               apply_config(5000, MAXP_CHL, 290, 500);
            end
         endcase
         repeat (PHASE_ITEMS) send_random_sample();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_gain_select();
      test_autorange_steps();
      test_negative_upper();
      test_random_phases();
      settle_idle();
      if (fail_count == 0)
         $display("PASS autorange_gain_ppb_converter_top");
      else
         $display("FAIL autorange_gain_ppb_converter_top");
      $finish;
   end

endmodule
`default_nettype wire

/* files.f */
hdl/agpc_pkg.sv
hdl/agpc_csr.sv
hdl/agpc_ctrl.sv
hdl/agpc_datapath.sv
hdl/autorange_gain_ppb_converter_top.sv
tb/autorange_gain_ppb_converter_top_test.sv
